### design/go_back_n_sender_assert.svh
// ---------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GBN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GBN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/gbn_pkg.sv
// ---------------------------------------------------------------------------
// Go-Back-N sender package
// Field widths, codes, control word layout and the microcode program.
// ---------------------------------------------------------------------------
package gbn_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int MAX_FRAMES_DEF = 1024;

    localparam int TOTAL_W     = 11;
    localparam int WINDOW_W    = 5;
    localparam int PCT_W       = 7;
    localparam int OUTCOME_W   = 7;
    localparam int KIND_W      = 3;
    localparam int FRAME_W     = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 4;

    localparam logic [TOTAL_W-1:0]  TOTAL_RST      = 11'd10;
    localparam logic [WINDOW_W-1:0] WINDOW_RST     = 5'd4;
    localparam logic [PCT_W-1:0]    FRAME_LOSS_RST = 7'd20;
    localparam logic [PCT_W-1:0]    ACK_LOSS_RST   = 7'd14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOTAL      = 4'd0,
        REG_WINDOW     = 4'd1,
        REG_FRAME_LOSS = 4'd2,
        REG_ACK_LOSS   = 4'd3
    } gbn_reg_t;

    typedef enum logic [2:0] {
        PH_SEND = 3'b001,
        PH_SCAN = 3'b010,
        PH_DONE = 3'b100
    } gbn_phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_SENT     = 3'd0,
        EV_LOST     = 3'd1,
        EV_ACK_OK   = 3'd2,
        EV_ACK_LOST = 3'd3,
        EV_SLID     = 3'd4,
        EV_TIMEOUT  = 3'd5,
        EV_DONE     = 3'd6
    } gbn_kind_t;

    typedef enum logic [3:0] {
        C_ALWAYS        = 4'd0,
        C_ACCEPT        = 4'd1,
        C_PH_DONE       = 4'd2,
        C_PH_SCAN       = 4'd3,
        C_LOST          = 4'd4,
        C_ACK_OK        = 4'd5,
        C_SEND_OK       = 4'd6,
        C_SCAN_MORE     = 4'd7,
        C_MARK          = 4'd8,
        C_BASE_LT_TOTAL = 4'd9
    } gbn_cond_sel_t;

    typedef enum logic [1:0] {
        FS_NEXT  = 2'd0,
        FS_SCAN  = 2'd1,
        FS_BASE  = 2'd2,
        FS_TOTAL = 2'd3
    } gbn_fsrc_t;

    typedef enum logic [1:0] {
        PT_HOLD = 2'd0,
        PT_INC  = 2'd1,
        PT_BASE = 2'd2
    } gbn_ptr_op_t;

    typedef enum logic {
        MS_SCAN = 1'b0,
        MS_BASE = 1'b1
    } gbn_mark_sel_t;

    localparam int UADDR_W = 5;
    typedef logic [UADDR_W-1:0] gbn_uaddr_t;

    localparam gbn_uaddr_t U_IDLE        = 5'd0;
    localparam gbn_uaddr_t U_CHECK_DONE  = 5'd1;
    localparam gbn_uaddr_t U_DISPATCH    = 5'd2;
    localparam gbn_uaddr_t U_SEND_DRAW   = 5'd3;
    localparam gbn_uaddr_t U_LOST        = 5'd4;
    localparam gbn_uaddr_t U_SENT        = 5'd5;
    localparam gbn_uaddr_t U_SEND_CHECK  = 5'd6;
    localparam gbn_uaddr_t U_SCAN_OPEN   = 5'd7;
    localparam gbn_uaddr_t U_SCAN_DRAW   = 5'd8;
    localparam gbn_uaddr_t U_ACK_LOST    = 5'd9;
    localparam gbn_uaddr_t U_ACK_OK      = 5'd10;
    localparam gbn_uaddr_t U_SCAN_SKIP   = 5'd11;
    localparam gbn_uaddr_t U_SCAN_MARK   = 5'd12;
    localparam gbn_uaddr_t U_SCAN_STEP   = 5'd13;
    localparam gbn_uaddr_t U_SLIDE_CHECK = 5'd14;
    localparam gbn_uaddr_t U_SLIDE_MARK  = 5'd15;
    localparam gbn_uaddr_t U_SLIDE       = 5'd16;
    localparam gbn_uaddr_t U_SLID        = 5'd17;
    localparam gbn_uaddr_t U_TIMEOUT     = 5'd18;
    localparam gbn_uaddr_t U_DONE        = 5'd19;
    localparam gbn_uaddr_t U_FINISH      = 5'd20;

    typedef struct packed {
        logic          ready;
        gbn_cond_sel_t cond_sel;
        logic          cond_inv;
        gbn_uaddr_t    target;
        logic          emit;
        gbn_kind_t     kind;
        gbn_fsrc_t     fsrc;
        gbn_ptr_op_t   next_op;
        gbn_ptr_op_t   scan_op;
        logic          base_inc;
        gbn_mark_sel_t mark_sel;
        logic          mark_wr;
        logic          mark_val;
        logic          phase_wr;
        gbn_phase_t    phase_val;
        logic          finish;
    } gbn_uword_t;

    typedef struct packed {
        logic accept;
        logic ph_done;
        logic ph_scan;
        logic lost;
        logic ack_ok;
        logic send_ok;
        logic scan_more;
        logic mark;
        logic base_lt_total;
    } gbn_cond_t;

    localparam gbn_uword_t UWORD_NOP = '{
        ready:     1'b0,
        cond_sel:  C_ALWAYS,
        cond_inv:  1'b1,
        target:    U_IDLE,
        emit:      1'b0,
        kind:      EV_SENT,
        fsrc:      FS_NEXT,
        next_op:   PT_HOLD,
        scan_op:   PT_HOLD,
        base_inc:  1'b0,
        mark_sel:  MS_SCAN,
        mark_wr:   1'b0,
        mark_val:  1'b0,
        phase_wr:  1'b0,
        phase_val: PH_SEND,
        finish:    1'b0
    };

    function automatic gbn_uword_t ucode(input gbn_uaddr_t addr);
        gbn_uword_t uw;
        uw = UWORD_NOP;
        case (addr)
            U_IDLE:
            begin
                uw.ready    = 1'b1;
                uw.cond_sel = C_ACCEPT;
                uw.target   = U_IDLE;
            end
            U_CHECK_DONE:
            begin
                uw.cond_sel = C_PH_DONE;
                uw.cond_inv = 1'b0;
                uw.target   = U_IDLE;
            end
            U_DISPATCH:
            begin
                uw.cond_sel = C_PH_SCAN;
                uw.cond_inv = 1'b0;
                uw.target   = U_SCAN_DRAW;
            end
            U_SEND_DRAW:
            begin
                uw.cond_sel = C_LOST;
                uw.target   = U_SENT;
            end
            U_LOST:
            begin
                uw.emit      = 1'b1;
                uw.kind      = EV_LOST;
                uw.fsrc      = FS_NEXT;
                uw.next_op   = PT_BASE;
                uw.scan_op   = PT_BASE;
                uw.phase_wr  = 1'b1;
                uw.phase_val = PH_SCAN;
                uw.cond_inv  = 1'b0;
                uw.target    = U_SCAN_SKIP;
            end
            U_SENT:
            begin
                uw.emit    = 1'b1;
                uw.kind    = EV_SENT;
                uw.fsrc    = FS_NEXT;
                uw.next_op = PT_INC;
            end
            U_SEND_CHECK:
            begin
                uw.cond_sel = C_SEND_OK;
                uw.cond_inv = 1'b0;
                uw.target   = U_FINISH;
            end
            U_SCAN_OPEN:
            begin
                uw.scan_op   = PT_BASE;
                uw.phase_wr  = 1'b1;
                uw.phase_val = PH_SCAN;
                uw.cond_inv  = 1'b0;
                uw.target    = U_SCAN_SKIP;
            end
            U_SCAN_DRAW:
            begin
                uw.cond_sel = C_ACK_OK;
                uw.cond_inv = 1'b0;
                uw.target   = U_ACK_OK;
            end
            U_ACK_LOST:
            begin
                uw.emit     = 1'b1;
                uw.kind     = EV_ACK_LOST;
                uw.fsrc     = FS_SCAN;
                uw.scan_op  = PT_INC;
                uw.cond_inv = 1'b0;
                uw.target   = U_SCAN_SKIP;
            end
            U_ACK_OK:
            begin
                uw.emit     = 1'b1;
                uw.kind     = EV_ACK_OK;
                uw.fsrc     = FS_SCAN;
                uw.scan_op  = PT_INC;
                uw.mark_sel = MS_SCAN;
                uw.mark_wr  = 1'b1;
                uw.mark_val = 1'b1;
            end
            U_SCAN_SKIP:
            begin
                uw.cond_sel = C_SCAN_MORE;
                uw.target   = U_SLIDE_CHECK;
            end
            U_SCAN_MARK:
            begin
                uw.cond_sel = C_MARK;
                uw.mark_sel = MS_SCAN;
                uw.target   = U_FINISH;
            end
            U_SCAN_STEP:
            begin
                uw.scan_op  = PT_INC;
                uw.cond_inv = 1'b0;
                uw.target   = U_SCAN_SKIP;
            end
            U_SLIDE_CHECK:
            begin
                uw.cond_sel = C_BASE_LT_TOTAL;
                uw.target   = U_DONE;
            end
            U_SLIDE_MARK:
            begin
                uw.cond_sel = C_MARK;
                uw.mark_sel = MS_BASE;
                uw.target   = U_TIMEOUT;
            end
            U_SLIDE:
            begin
                uw.base_inc = 1'b1;
                uw.mark_sel = MS_BASE;
                uw.mark_wr  = 1'b1;
                uw.mark_val = 1'b0;
            end
            U_SLID:
            begin
                uw.emit     = 1'b1;
                uw.kind     = EV_SLID;
                uw.fsrc     = FS_BASE;
                uw.cond_inv = 1'b0;
                uw.target   = U_SLIDE_CHECK;
            end
            U_TIMEOUT:
            begin
                uw.emit      = 1'b1;
                uw.kind      = EV_TIMEOUT;
                uw.fsrc      = FS_BASE;
                uw.next_op   = PT_BASE;
                uw.phase_wr  = 1'b1;
                uw.phase_val = PH_SEND;
                uw.cond_inv  = 1'b0;
                uw.target    = U_SEND_CHECK;
            end
            U_DONE:
            begin
                uw.emit      = 1'b1;
                uw.kind      = EV_DONE;
                uw.fsrc      = FS_TOTAL;
                uw.phase_wr  = 1'b1;
                uw.phase_val = PH_DONE;
            end
            U_FINISH:
            begin
                uw.finish   = 1'b1;
                uw.cond_inv = 1'b0;
                uw.target   = U_IDLE;
            end
            default:
            begin
                uw.cond_inv = 1'b0;
                uw.target   = U_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

### design/gbn_useq.sv
// ---------------------------------------------------------------------------
// Go-Back-N sender microsequencer
// Step counter over the microcode table with conditional jumps.
// ---------------------------------------------------------------------------
module gbn_useq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic               hold,
    input  gbn_pkg::gbn_cond_t cond,
    output gbn_pkg::gbn_uword_t uword
);

    gbn_pkg::gbn_uaddr_t upc_reg;
    gbn_pkg::gbn_uaddr_t upc_next;
    logic                cond_hit;
    logic                take;

    assign uword = gbn_pkg::ucode(upc_reg);

    always_comb
    begin
        case (uword.cond_sel)
            gbn_pkg::C_ALWAYS:        cond_hit = 1'b1;
            gbn_pkg::C_ACCEPT:        cond_hit = cond.accept;
            gbn_pkg::C_PH_DONE:       cond_hit = cond.ph_done;
            gbn_pkg::C_PH_SCAN:       cond_hit = cond.ph_scan;
            gbn_pkg::C_LOST:          cond_hit = cond.lost;
            gbn_pkg::C_ACK_OK:        cond_hit = cond.ack_ok;
            gbn_pkg::C_SEND_OK:       cond_hit = cond.send_ok;
            gbn_pkg::C_SCAN_MORE:     cond_hit = cond.scan_more;
            gbn_pkg::C_MARK:          cond_hit = cond.mark;
            gbn_pkg::C_BASE_LT_TOTAL: cond_hit = cond.base_lt_total;
            default:                  cond_hit = 1'b0;
        endcase
        take = cond_hit ^ uword.cond_inv;
        if (restart)
        begin
            upc_next = gbn_pkg::U_IDLE;
        end
        else if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (take)
        begin
            upc_next = uword.target;
        end
        else
        begin
            upc_next = gbn_pkg::gbn_uaddr_t'(upc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= gbn_pkg::U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

### design/go_back_n_sender.sv
// ---------------------------------------------------------------------------
// Go-Back-N sender
// Go-Back-N ARQ sender run driven by channel outcomes (0..127), one per input
// transfer. Each outcome is taken once the program has gone back to idle after
// the previous one. It then runs in the send phase or the ack scan. The scan is
// opened when the window is full or every frame is out, skips acknowledged
// frames, and is followed by window slides and then a timeout or done. A lost
// frame leads on to its timeout. A microcode program runs one control word a
// cycle over the datapath, and a result waiting at a stalled output holds the
// program. Results come out one per transfer, with last set on the final result
// of each outcome. A write to one of the four registers restarts the run; writes
// are to be made only while the block is idle, which the block does not enforce.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`include "go_back_n_sender_assert.svh"

module go_back_n_sender #(
    parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF,
    parameter int MAX_FRAMES = gbn_pkg::MAX_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [gbn_pkg::OUTCOME_W-1:0]   outcome,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gbn_pkg::KIND_W-1:0]      event_kind,
    output logic [gbn_pkg::FRAME_W-1:0]     frame_number,
    output logic                            last
);

    localparam int FW  = $clog2(MAX_FRAMES + 1);
    localparam int SW  = $clog2(MAX_FRAMES + WINDOW_MAX + 1);
    localparam int WVW = $clog2(WINDOW_MAX + 1);
    localparam int WCW = (WVW > gbn_pkg::WINDOW_W) ? WVW : gbn_pkg::WINDOW_W;
    localparam int TCW = (FW > gbn_pkg::TOTAL_W) ? FW : gbn_pkg::TOTAL_W;
    localparam int SLW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [TCW-1:0] TOTAL_CAP  = TCW'(MAX_FRAMES);
    localparam logic [WCW-1:0] WINDOW_CAP = WCW'(WINDOW_MAX);
    localparam logic [SLW-1:0] SLOT_LAST  = SLW'(WINDOW_MAX - 1);

    logic [gbn_pkg::TOTAL_W-1:0]  cfg_total_reg, cfg_total_next;
    logic [gbn_pkg::WINDOW_W-1:0] cfg_window_reg, cfg_window_next;
    logic [gbn_pkg::PCT_W-1:0]    cfg_floss_reg, cfg_floss_next;
    logic [gbn_pkg::PCT_W-1:0]    cfg_aloss_reg, cfg_aloss_next;
    logic                         restart;

    gbn_pkg::gbn_phase_t phase_reg, phase_next;
    logic [FW-1:0]       base_reg, base_next;
    logic [FW-1:0]       next_reg, next_next;
    logic [FW-1:0]       scan_reg, scan_next;
    logic [SLW-1:0]      base_slot_reg, base_slot_next;
    logic [SLW-1:0]      scan_slot_reg, scan_slot_next;
    logic [WINDOW_MAX-1:0] marks_reg, marks_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic [gbn_pkg::OUTCOME_W-1:0] draw_reg;
    gbn_pkg::gbn_kind_t            pend_kind_reg;
    logic [FW-1:0]                 pend_frame_reg;
    logic [gbn_pkg::KIND_W-1:0]    out_kind_reg;
    logic [gbn_pkg::FRAME_W-1:0]   out_frame_reg;
    logic                          out_last_reg;

    gbn_pkg::gbn_uword_t uword;
    gbn_pkg::gbn_cond_t  cond;

    logic [TCW-1:0]      total_ext;
    logic [FW-1:0]       eff_total;
    logic [WCW-1:0]      window_ext;
    logic [WVW-1:0]      eff_window;
    logic [SW-1:0]       base_plus_win;
    logic [SLW-1:0]      mark_addr;
    logic [FW-1:0]       frame_src;
    logic [FW+gbn_pkg::FRAME_W-1:0] frame_wide;
    logic                push_need;
    logic                out_free;
    logic                hold;
    logic                push;
    logic                adv;

    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
        return (s == SLOT_LAST) ? '0 : SLW'(s + 1'b1);
    endfunction

    // configuration registers
    always_comb
    begin
        cfg_total_next  = cfg_total_reg;
        cfg_window_next = cfg_window_reg;
        cfg_floss_next  = cfg_floss_reg;
        cfg_aloss_next  = cfg_aloss_reg;
        restart         = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                gbn_pkg::REG_TOTAL:
                begin
                    cfg_total_next = cfg_data[gbn_pkg::TOTAL_W-1:0];
                    restart        = 1'b1;
                end
                gbn_pkg::REG_WINDOW:
                begin
                    cfg_window_next = cfg_data[gbn_pkg::WINDOW_W-1:0];
                    restart         = 1'b1;
                end
                gbn_pkg::REG_FRAME_LOSS:
                begin
                    cfg_floss_next = cfg_data[gbn_pkg::PCT_W-1:0];
                    restart        = 1'b1;
                end
                gbn_pkg::REG_ACK_LOSS:
                begin
                    cfg_aloss_next = cfg_data[gbn_pkg::PCT_W-1:0];
                    restart        = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // clamp total and window
    always_comb
    begin
        total_ext  = TCW'(cfg_total_reg);
        window_ext = WCW'(cfg_window_reg);
        if (total_ext == '0)
        begin
            eff_total = FW'(1);
        end
        else if (total_ext > TOTAL_CAP)
        begin
            eff_total = FW'(TOTAL_CAP);
        end
        else
        begin
            eff_total = FW'(total_ext);
        end
        if (window_ext == '0)
        begin
            eff_window = WVW'(1);
        end
        else if (window_ext > WINDOW_CAP)
        begin
            eff_window = WVW'(WINDOW_CAP);
        end
        else
        begin
            eff_window = WVW'(window_ext);
        end
    end

    assign base_plus_win = SW'(base_reg) + SW'(eff_window);
    assign mark_addr     = (uword.mark_sel == gbn_pkg::MS_BASE) ? base_slot_reg : scan_slot_reg;

    assign in_stall = !uword.ready;

    always_comb
    begin
        cond.accept        = in_valid && !in_stall;
        cond.ph_done       = (phase_reg == gbn_pkg::PH_DONE);
        cond.ph_scan       = (phase_reg == gbn_pkg::PH_SCAN);
        cond.lost          = (draw_reg < cfg_floss_reg);
        cond.ack_ok        = (draw_reg >= cfg_aloss_reg);
        cond.send_ok       = (SW'(next_reg) < base_plus_win) && (next_reg < eff_total);
        cond.scan_more     = (scan_reg < next_reg) && (scan_reg < eff_total);
        cond.mark          = marks_reg[mark_addr];
        cond.base_lt_total = (base_reg < eff_total);
    end

    gbn_useq u_useq (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .hold    (hold),
        .cond    (cond),
        .uword   (uword)
    );

    always_comb
    begin
        case (uword.fsrc)
            gbn_pkg::FS_NEXT:  frame_src = next_reg;
            gbn_pkg::FS_SCAN:  frame_src = scan_reg;
            gbn_pkg::FS_BASE:  frame_src = base_reg;
            gbn_pkg::FS_TOTAL: frame_src = eff_total;
            default:           frame_src = next_reg;
        endcase
    end

    // a new result or the end of the program moves the held result out
    assign push_need = (uword.emit || uword.finish) && pend_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign hold      = push_need && !out_free;
    assign push      = push_need && out_free;
    assign adv       = !hold;

    always_comb
    begin
        phase_next      = phase_reg;
        base_next       = base_reg;
        next_next       = next_reg;
        scan_next       = scan_reg;
        base_slot_next  = base_slot_reg;
        scan_slot_next  = scan_slot_reg;
        marks_next      = marks_reg;
        pend_valid_next = pend_valid_reg;
        if (restart)
        begin
            phase_next      = gbn_pkg::PH_SEND;
            base_next       = '0;
            next_next       = '0;
            scan_next       = '0;
            base_slot_next  = '0;
            scan_slot_next  = '0;
            marks_next      = '0;
            pend_valid_next = 1'b0;
        end
        else if (adv)
        begin
            if (uword.phase_wr)
            begin
                phase_next = uword.phase_val;
            end
            case (uword.next_op)
                gbn_pkg::PT_INC:  next_next = FW'(next_reg + 1'b1);
                gbn_pkg::PT_BASE: next_next = base_reg;
                default:          next_next = next_reg;
            endcase
            case (uword.scan_op)
                gbn_pkg::PT_INC:
                begin
                    scan_next      = FW'(scan_reg + 1'b1);
                    scan_slot_next = slot_inc(scan_slot_reg);
                end
                gbn_pkg::PT_BASE:
                begin
                    scan_next      = base_reg;
                    scan_slot_next = base_slot_reg;
                end
                default:
                begin
                    scan_next      = scan_reg;
                    scan_slot_next = scan_slot_reg;
                end
            endcase
            if (uword.base_inc)
            begin
                base_next      = FW'(base_reg + 1'b1);
                base_slot_next = slot_inc(base_slot_reg);
            end
            if (uword.mark_wr)
            begin
                marks_next[mark_addr] = uword.mark_val;
            end
            if (uword.emit)
            begin
                pend_valid_next = 1'b1;
            end
            else if (uword.finish)
            begin
                pend_valid_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign frame_wide = {{gbn_pkg::FRAME_W{1'b0}}, pend_frame_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_total_reg  <= gbn_pkg::TOTAL_RST;
            cfg_window_reg <= gbn_pkg::WINDOW_RST;
            cfg_floss_reg  <= gbn_pkg::FRAME_LOSS_RST;
            cfg_aloss_reg  <= gbn_pkg::ACK_LOSS_RST;
            phase_reg      <= gbn_pkg::PH_SEND;
            base_reg       <= '0;
            next_reg       <= '0;
            scan_reg       <= '0;
            base_slot_reg  <= '0;
            scan_slot_reg  <= '0;
            marks_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_total_reg  <= cfg_total_next;
            cfg_window_reg <= cfg_window_next;
            cfg_floss_reg  <= cfg_floss_next;
            cfg_aloss_reg  <= cfg_aloss_next;
            phase_reg      <= phase_next;
            base_reg       <= base_next;
            next_reg       <= next_next;
            scan_reg       <= scan_next;
            base_slot_reg  <= base_slot_next;
            scan_slot_reg  <= scan_slot_next;
            marks_reg      <= marks_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cond.accept)
        begin
            draw_reg <= outcome;
        end
        if (adv && uword.emit)
        begin
            pend_kind_reg  <= uword.kind;
            pend_frame_reg <= frame_src;
        end
        if (push)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_frame_reg <= frame_wide[gbn_pkg::FRAME_W-1:0];
            out_last_reg  <= uword.finish;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign frame_number = out_frame_reg;
    assign last         = out_last_reg;

    `GBN_ASSERT_IMP(a_idle_no_pending, clk, rst_n, uword.ready, !pend_valid_reg,
                    "result held at idle")
    `GBN_ASSERT_IMP(a_ptrs_in_run, clk, rst_n, 1'b1,
                    (next_reg <= eff_total) && (base_reg <= eff_total),
                    "frame pointer past total")
    `GBN_ASSERT_NXT(a_finish_marks_last, clk, rst_n, uword.finish && !hold && !restart,
                    out_valid_reg && out_last_reg, "final transfer not marked last")

endmodule

### tb/gbn_sender_checker.sv
// ---------------------------------------------------------------------------
// Go-Back-N sender checker
// Watches the configuration port and both channels of the sender. It keeps its
// own copy of the registers and of the Go-Back-N run, works out the events
// that each accepted outcome causes and compares every result transfer, field
// by field, with the oldest expected event. It reports the mismatch count, the
// events still awaited, the outcomes that drove the run and whether the run
// is over.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gbn_sender_checker
    import gbn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [OUTCOME_W-1:0]   outcome,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [KIND_W-1:0]      event_kind,
    input  logic [FRAME_W-1:0]     frame_number,
    input  logic                   last,
    output int unsigned            mismatches,
    output int unsigned            outstanding,
    output int unsigned            useful_items,
    output logic                   run_over
);

    localparam int unsigned RING       = WINDOW_MAX_DEF;
    localparam int unsigned MAX_EVENTS = 18;

    typedef struct packed {
        gbn_kind_t          kind;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } sender_event_t;

    logic [TOTAL_W-1:0]  total_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [PCT_W-1:0]    frame_loss_reg;
    logic [PCT_W-1:0]    ack_loss_reg;

    gbn_phase_t          run_phase;
    int unsigned         base_frame;
    int unsigned         next_out;
    int unsigned         scan_at;
    logic [RING-1:0]     ack_ring;

    sender_event_t       expected_events[$];
    sender_event_t       step_events[$];
    int unsigned         errs;
    int unsigned         driving_items;

    task automatic restart_run();
        run_phase  = PH_SEND;
        base_frame = 0;
        next_out   = 0;
        scan_at    = 0;
        ack_ring   = '0;
    endtask

    task automatic note_event(input gbn_kind_t kind, input int unsigned frame);
        sender_event_t ev;
        ev.kind  = kind;
        ev.frame = frame[FRAME_W-1:0];
        ev.last  = 1'b0;
        if (step_events.size() < MAX_EVENTS)
            step_events.push_back(ev);
    endtask

    task automatic predict_sender_events(input logic [OUTCOME_W-1:0] draw);
        int unsigned total_eff;
        int unsigned window_eff;
        step_events.delete();
        if (run_phase == PH_DONE)
            return;
        driving_items++;
        total_eff  = (total_reg == 0) ? 1 : total_reg;
        if (total_eff > MAX_FRAMES_DEF)
            total_eff = MAX_FRAMES_DEF;
        window_eff = (window_reg == 0) ? 1 : window_reg;
        if (window_eff > WINDOW_MAX_DEF)
            window_eff = WINDOW_MAX_DEF;

        if (run_phase == PH_SEND)
        begin
            if (draw < frame_loss_reg)
            begin
                note_event(EV_LOST, next_out);
                next_out  = base_frame;
                run_phase = PH_SCAN;
                scan_at   = base_frame;
            end
            else
            begin
                note_event(EV_SENT, next_out);
                next_out++;
            end
        end
        else
        begin
            if (draw >= ack_loss_reg)
            begin
                note_event(EV_ACK_OK, scan_at);
                ack_ring[scan_at % RING] = 1'b1;
            end
            else
                note_event(EV_ACK_LOST, scan_at);
            scan_at++;
        end

        // carry on until the next draw is needed or the run is over
        forever
        begin
            if (run_phase == PH_SEND)
            begin
                if (next_out < base_frame + window_eff && next_out < total_eff)
                    break;
                run_phase = PH_SCAN;
                scan_at   = base_frame;
            end
            while (scan_at < next_out && scan_at < total_eff && ack_ring[scan_at % RING])
                scan_at++;
            if (scan_at < next_out && scan_at < total_eff)
                break;
            while (base_frame < total_eff && ack_ring[base_frame % RING])
            begin
                ack_ring[base_frame % RING] = 1'b0;
                base_frame++;
                note_event(EV_SLID, base_frame);
            end
            if (base_frame < total_eff)
            begin
                note_event(EV_TIMEOUT, base_frame);
                next_out  = base_frame;
                run_phase = PH_SEND;
            end
            else
            begin
                note_event(EV_DONE, total_eff);
                run_phase = PH_DONE;
                break;
            end
        end

        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endtask

    task automatic check_result();
        sender_event_t want;
        if (expected_events.size() == 0)
        begin
            $error("unexpected result: event_kind %0d frame_number %0d last %0d",
                   event_kind, frame_number, last);
            errs++;
            return;
        end
        want = expected_events.pop_front();
        if (event_kind !== want.kind)
        begin
            $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
            errs++;
        end
        if (frame_number !== want.frame)
        begin
            $error("frame_number: expected %0d, actual %0d", want.frame, frame_number);
            errs++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      = TOTAL_RST;
            window_reg     = WINDOW_RST;
            frame_loss_reg = FRAME_LOSS_RST;
            ack_loss_reg   = ACK_LOSS_RST;
            restart_run();
            expected_events.delete();
            errs           = 0;
            driving_items  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOTAL:
                    begin
                        total_reg = cfg_data[TOTAL_W-1:0];
                        restart_run();
                    end
                    REG_WINDOW:
                    begin
                        window_reg = cfg_data[WINDOW_W-1:0];
                        restart_run();
                    end
                    REG_FRAME_LOSS:
                    begin
                        frame_loss_reg = cfg_data[PCT_W-1:0];
                        restart_run();
                    end
                    REG_ACK_LOSS:
                    begin
                        ack_loss_reg = cfg_data[PCT_W-1:0];
                        restart_run();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                predict_sender_events(outcome);
            if (out_valid && !out_stall)
                check_result();
        end
        mismatches   <= errs;
        outstanding  <= expected_events.size();
        useful_items <= driving_items;
        run_over     <= (run_phase == PH_DONE);
    end

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// Go-Back-N sender testbench
// Resets the sender, runs a short directed sequence over the default
// registers, clamped and extreme settings, a run to completion and a stray
// register index, then many randomly configured runs of random outcomes with
// bursts of idling on both channels. The checker beside the block predicts
// and compares every result; this module drives stimulus and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import gbn_pkg::*;

    localparam int unsigned ITEM_TARGET   = 205;
    localparam int unsigned CALM_ITEMS    = 30;
    localparam int unsigned PHASE_CAP     = 80;
    localparam int unsigned PAUSE_EVERY   = 17;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [OUTCOME_W-1:0]   outcome;
    logic                   out_valid;
    logic                   out_stall;
    logic [KIND_W-1:0]      event_kind;
    logic [FRAME_W-1:0]     frame_number;
    logic                   last;

    int unsigned            mismatches;
    int unsigned            outstanding;
    int unsigned            useful_items;
    logic                   run_over;

    int unsigned            send_gap_pct = 0;
    int unsigned            stall_pct    = 0;
    logic                   calm         = 1'b0;
    int unsigned            quiet_cycles;

    go_back_n_sender DUT (.*);

    gbn_sender_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 45;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_run(input logic [CFG_DATA_W-1:0] total,
                               input logic [CFG_DATA_W-1:0] window,
                               input logic [CFG_DATA_W-1:0] frame_loss,
                               input logic [CFG_DATA_W-1:0] ack_loss,
                               input bit stray);
        write_reg(REG_TOTAL, total);
        write_reg(REG_WINDOW, window);
        write_reg(REG_FRAME_LOSS, frame_loss);
        write_reg(REG_ACK_LOSS, ack_loss);
        if (stray)
            write_reg(CFG_INDEX_W'($urandom_range(REG_ACK_LOSS + 1, REG_INDEX_TOP)),
                      CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_outcome(input logic [OUTCOME_W-1:0] draw);
        in_valid <= 1'b1;
        outcome  <= draw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver side: random stall bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        logic [OUTCOME_W-1:0] draws[$];
        int unsigned          target;
        int unsigned          phase_items;
        logic [CFG_DATA_W-1:0] total;

        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_TOTAL;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        outcome   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 20;
        stall_pct    = 20;

        // default registers: losses at both thresholds, a timeout with base
        // unacknowledged, then a full window acknowledged and slid
        draws = '{7'd0, 7'd127, 7'd99, 7'd20, 7'd100, 7'd13, 7'd14, 7'd127, 7'd0,
                  7'd19, 7'd64, 7'd64, 7'd64, 7'd64, 7'd99, 7'd99, 7'd99, 7'd99};
        foreach (draws[i])
        begin
            send_outcome(draws[i]);
            sender_gap();
        end
        wait_until_idle();

        // zero total and window act as one; run to completion
        program_run('0, '0, '0, '0, 1'b0);
        draws = '{7'd85, 7'd42};
        foreach (draws[i])
        begin
            send_outcome(draws[i]);
            sender_gap();
        end
        wait_until_idle();

        // stray index must not restart the finished run
        write_reg(REG_INDEX_TOP, '1);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_outcome(7'd7);
        wait_until_idle();

        // oversized total and window, thresholds at the largest outcome value
        program_run('1, CFG_DATA_W'(31), CFG_DATA_W'(127), CFG_DATA_W'(127), 1'b0);
        draws = '{7'd126, 7'd5};
        foreach (draws[i])
        begin
            send_outcome(draws[i]);
            sender_gap();
        end
        wait_until_idle();

        target = useful_items + ITEM_TARGET;
        while (useful_items < target)
        begin
            send_gap_pct = idle_pct();
            stall_pct    = idle_pct();
            case ($urandom_range(9))
                0:       total = CFG_DATA_W'($urandom_range(0, 2047));
                1:       total = CFG_DATA_W'($urandom_range(0, 1));
                default: total = CFG_DATA_W'($urandom_range(1, 24));
            endcase
            program_run(total,
                        CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(1, 16)),
                        CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 35)),
                        CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 35)),
                        $urandom_range(5) == 0);
            phase_items = 0;
            while (!run_over && phase_items < PHASE_CAP && useful_items < target)
            begin
                calm <= (useful_items + CALM_ITEMS >= target);
                send_outcome(OUTCOME_W'(($urandom_range(9) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(0, 99)));
                phase_items++;
                // hold the sender until every awaited result has come
                if (phase_items % PAUSE_EVERY == PAUSE_EVERY - 1)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (outstanding != 0);
                end
                else
                    sender_gap();
            end
            wait_until_idle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
